// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

    localparam int ARR_W         = 10;
    localparam int BURST_W       = 10;
    localparam int PRIO_W        = 8;
    localparam int TOUT_W        = 15;
    localparam int JOB_IDX_W     = 4;
    localparam int DEF_NUM_SLOTS = 16;

    localparam logic [TOUT_W-1:0] TIME_MAX = {TOUT_W{1'b1}};

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] remain;
        logic [TOUT_W-1:0]  finish;
    } t_job_rec;

    typedef struct packed {
        logic clear;
        logic eval;
    } t_pick_ctl;

endpackage

// File: rtl/pps_job_store.sv
`timescale 1ns / 1ps

module pps_job_store #(
    parameter int NUM_SLOTS = pps_pkg::DEF_NUM_SLOTS,
    parameter int IDX_W     = $clog2(NUM_SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  pps_pkg::t_job_rec i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output pps_pkg::t_job_rec o_rdata
);
    import pps_pkg::*;

    t_job_rec r_mem [NUM_SLOTS];
    t_job_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pps_pick_unit.sv
`timescale 1ns / 1ps

module pps_pick_unit #(
    parameter int IDX_W  = 4,
    parameter int TIME_W = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pps_pkg::t_pick_ctl i_ctl,
    input  pps_pkg::t_job_rec i_cand,
    input  logic [IDX_W-1:0]  i_cand_idx,
    input  logic [TIME_W-1:0] i_now,
    output logic              o_found,
    output pps_pkg::t_job_rec o_best,
    output logic [IDX_W-1:0]  o_best_idx
);
    import pps_pkg::*;

    logic             r_found;
    t_job_rec         r_best;
    logic [IDX_W-1:0] r_best_idx;
    logic             n_take;

    assign n_take = i_ctl.eval && (i_cand.remain != '0)
                    && (TIME_W'(i_cand.arrival) <= i_now)
                    && (!r_found || (i_cand.prio < r_best.prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (n_take) begin
            r_found <= 1'b1;
        end
        if (n_take) begin
            r_best     <= i_cand;
            r_best_idx <= i_cand_idx;
        end
    end

    assign o_found    = r_found;
    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

// File: rtl/preemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps

// Preemptive priority scheduler. Each accepted request (start high while busy is low) loads one
// job. The job marked last, or the one that fills all NUM_SLOTS slots, starts the run: time is
// simulated one unit at a time; for each unit one comparator walks the job memory one slot per
// cycle, then the picked job is written back. Idle units cost the same as busy ones. Results
// then come out one per cycle in load order, one cycle each with o_valid high, after the
// registered memory read and the output registers; o_last_result marks the final one. The
// receiver cannot stall, so results must be taken as they appear. busy rises after the last
// job and drops in the cycle that carries the last result, so the next set can load from that
// cycle on.
module preemptive_priority_scheduler_core #(
    parameter int NUM_SLOTS = pps_pkg::DEF_NUM_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pps_pkg::ARR_W-1:0]       i_arrival_time,
    input  logic [pps_pkg::BURST_W-1:0]     i_burst_time,
    input  logic [pps_pkg::PRIO_W-1:0]      i_priority_req,
    input  logic                            i_last_job,
    output logic                            o_valid,
    output logic [pps_pkg::JOB_IDX_W-1:0]   o_job_index,
    output logic [pps_pkg::TOUT_W-1:0]      o_finish_time,
    output logic [pps_pkg::TOUT_W-1:0]      o_turn_time,
    output logic [pps_pkg::TOUT_W-1:0]      o_wait_units,
    output logic                            o_last_result
);
    import pps_pkg::*;

    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int TRAW_W  = ARR_W + $clog2(NUM_SLOTS) + 1;
    localparam int TIME_W  = (TRAW_W > TOUT_W) ? TRAW_W : TOUT_W;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_UPD,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_fin_cnt;
    logic [CNT_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [TIME_W-1:0]  r_now;
    logic               r_valid;
    logic               r_last;
    logic [JOB_IDX_W-1:0] r_job_index;
    logic [TOUT_W-1:0]  r_comp;
    logic [TOUT_W-1:0]  r_tat;
    logic [TOUT_W-1:0]  r_wt;

    logic               n_we;
    logic [IDX_W-1:0]   n_waddr;
    t_job_rec           n_wdata;
    t_job_rec           rd_rec;
    t_pick_ctl          pick_ctl;
    logic               pick_found;
    t_job_rec           pick_best;
    logic [IDX_W-1:0]   pick_idx;
    logic [BURST_W-1:0] n_burst;
    logic [CNT_W-1:0]   n_count_inc;
    logic [CNT_W-1:0]   n_fin_inc;
    logic [TIME_W:0]    n_now_inc;
    logic [TOUT_W-1:0]  n_finish;
    logic [TOUT_W-1:0]  n_tat;
    logic [TOUT_W-1:0]  n_wt;
    logic               n_done;
    logic               n_rd_last;

    assign n_burst     = (i_burst_time == '0) ? BURST_W'(1) : i_burst_time;
    assign n_count_inc = r_count + 1'b1;
    assign n_fin_inc   = r_fin_cnt + 1'b1;
    assign n_now_inc   = {1'b0, r_now} + 1'b1;
    assign n_finish    = (n_now_inc > (TIME_W + 1)'(TIME_MAX)) ? TIME_MAX
                                                                : TOUT_W'(n_now_inc);
    assign n_done      = pick_found && (pick_best.remain == BURST_W'(1));
    assign n_rd_last   = (CNT_W'(r_rd_idx) == (r_count - 1'b1));

    always_comb begin
        n_tat = '0;
        n_wt  = '0;
        if (rd_rec.finish > TOUT_W'(rd_rec.arrival)) begin
            n_tat = rd_rec.finish - TOUT_W'(rd_rec.arrival);
        end
        if (n_tat > TOUT_W'(rd_rec.burst)) begin
            n_wt = n_tat - TOUT_W'(rd_rec.burst);
        end
    end

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_count[IDX_W-1:0];
        n_wdata = '{arrival: i_arrival_time, burst: n_burst, prio: i_priority_req,
                    remain: n_burst, finish: '0};
        case (r_state)
            S_LOAD: begin
                n_we = start;
            end
            S_UPD: begin
                n_we           = pick_found;
                n_waddr        = pick_idx;
                n_wdata        = pick_best;
                n_wdata.remain = pick_best.remain - 1'b1;
                if (n_done) begin
                    n_wdata.finish = n_finish;
                end
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    assign pick_ctl.clear = (r_state == S_UPD);
    assign pick_ctl.eval  = (r_state == S_SCAN) && r_rd_vld;

    pps_job_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_rec)
    );

    pps_pick_unit #(
        .IDX_W  (IDX_W),
        .TIME_W (TIME_W)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pick_ctl),
        .i_cand     (rd_rec),
        .i_cand_idx (r_rd_idx),
        .i_now      (r_now),
        .o_found    (pick_found),
        .o_best     (pick_best),
        .o_best_idx (pick_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_fin_cnt <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_now     <= '0;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_valid <= (r_state == S_OUT) && r_rd_vld;
            r_last  <= (r_state == S_OUT) && r_rd_vld && n_rd_last;
            case (r_state)
                S_LOAD: begin
                    r_addr   <= '0;
                    r_rd_vld <= 1'b0;
                    if (start) begin
                        r_count <= n_count_inc;
                        if (i_last_job || (n_count_inc == CNT_W'(NUM_SLOTS))) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= (r_addr < r_count);
                    r_rd_idx <= r_addr[IDX_W-1:0];
                    if (r_addr < r_count) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if ((r_addr == r_count) && r_rd_vld) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_now    <= n_now_inc[TIME_W-1:0];
                    r_addr   <= '0;
                    r_rd_vld <= 1'b0;
                    if (n_done && (n_fin_inc == r_count)) begin
                        r_fin_cnt <= n_fin_inc;
                        r_state   <= S_OUT;
                    end else begin
                        if (n_done) begin
                            r_fin_cnt <= n_fin_inc;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_OUT: begin
                    if (r_rd_vld) begin
                        r_job_index <= JOB_IDX_W'(r_rd_idx);
                        r_comp      <= rd_rec.finish;
                        r_tat       <= n_tat;
                        r_wt        <= n_wt;
                    end
                    if (r_rd_vld && n_rd_last) begin
                        r_state   <= S_LOAD;
                        r_count   <= '0;
                        r_fin_cnt <= '0;
                        r_now     <= '0;
                        r_addr    <= '0;
                        r_rd_vld  <= 1'b0;
                    end else begin
                        r_rd_vld <= (r_addr < r_count);
                        r_rd_idx <= r_addr[IDX_W-1:0];
                        if (r_addr < r_count) begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_LOAD);
    assign o_valid       = r_valid;
    assign o_job_index   = r_job_index;
    assign o_finish_time = r_comp;
    assign o_turn_time   = r_tat;
    assign o_wait_units  = r_wt;
    assign o_last_result = r_last;

`ifndef SYNTH
    a_fin_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_cnt <= r_count)
        else $error("finished count exceeds job count");

    a_burst_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_result |=> o_valid)
        else $error("result burst broken before last result");

    a_tat_le_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_turn_time <= o_finish_time))
        else $error("turnaround exceeds completion time");

    a_wt_le_tat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_wait_units < o_turn_time))
        else $error("waiting time not below turnaround time");

    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count == $past(r_count)))
        else $error("job count changed during run");
`endif

endmodule

// File: sim/tb_preemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_core;

    import pps_pkg::*;

    localparam int RANDOM_JOBS = 128;

    typedef struct {
        logic [JOB_IDX_W-1:0] job_index;
        logic [TOUT_W-1:0]    completion;
        logic [TOUT_W-1:0]    turnaround;
        logic [TOUT_W-1:0]    waiting;
        logic                 last;
    } t_job_timing;

    class t_timing_board;
        logic [ARR_W-1:0]   arrival_q[DEF_NUM_SLOTS];
        logic [BURST_W-1:0] burst_q[DEF_NUM_SLOTS];
        logic [PRIO_W-1:0]  prio_q[DEF_NUM_SLOTS];
        t_job_timing        timings_due[$];
        int loaded;
        int jobs_seen;
        int schedules;
        int full_starts;
        int latest_finish;
        int checked;
        int errors;

        function new();
            loaded        = 0;
            jobs_seen     = 0;
            schedules     = 0;
            full_starts   = 0;
            latest_finish = 0;
            checked       = 0;
            errors        = 0;
        endfunction

        function logic [TOUT_W-1:0] clip_time(int v);
            return (v > int'(TIME_MAX)) ? TIME_MAX : TOUT_W'(v);
        endfunction

        function void simulate_schedule();
            int          left[DEF_NUM_SLOTS];
            int          fin[DEF_NUM_SLOTS];
            int          now;
            int          done;
            int          pick;
            int          tat;
            int          wt;
            bit          found;
            t_job_timing r;
            for (int i = 0; i < loaded; i++) begin
                left[i] = int'(burst_q[i]);
                fin[i]  = 0;
            end
            now  = 0;
            done = 0;
            while (done < loaded) begin
                found = 0;
                pick  = 0;
                for (int i = 0; i < loaded; i++) begin
                    if (left[i] > 0 && int'(arrival_q[i]) <= now) begin
                        if (!found || prio_q[i] < prio_q[pick]) begin
                            pick  = i;
                            found = 1;
                        end
                    end
                end
                if (found) begin
                    left[pick]--;
                    if (left[pick] == 0) begin
                        fin[pick] = now + 1;
                        done++;
                    end
                end
                now++;
            end
            for (int i = 0; i < loaded; i++) begin
                tat = (fin[i] > int'(arrival_q[i])) ? fin[i] - int'(arrival_q[i]) : 0;
                wt  = (tat > int'(burst_q[i])) ? tat - int'(burst_q[i]) : 0;
                r.job_index  = JOB_IDX_W'(i);
                r.completion = clip_time(fin[i]);
                r.turnaround = clip_time(tat);
                r.waiting    = clip_time(wt);
                r.last       = (i == loaded - 1);
                timings_due.push_back(r);
            end
            if (now > latest_finish) begin
                latest_finish = now;
            end
            schedules++;
            loaded = 0;
        endfunction

        function void note_job(logic [ARR_W-1:0] arr, logic [BURST_W-1:0] bur,
                               logic [PRIO_W-1:0] pr, logic last);
            arrival_q[loaded] = arr;
            burst_q[loaded]   = (bur == '0) ? BURST_W'(1) : bur;
            prio_q[loaded]    = pr;
            loaded++;
            jobs_seen++;
            if (loaded == DEF_NUM_SLOTS) begin
                full_starts++;
            end
            if (last || loaded == DEF_NUM_SLOTS) begin
                simulate_schedule();
            end
        endfunction

        function void check_result(logic [JOB_IDX_W-1:0] idx, logic [TOUT_W-1:0] comp,
                                   logic [TOUT_W-1:0] tat, logic [TOUT_W-1:0] wt,
                                   logic last);
            t_job_timing want;
            if (timings_due.size() == 0) begin
                $error("result with nothing pending: job_index %0d", idx);
                errors++;
                return;
            end
            want = timings_due.pop_front();
            checked++;
            if (idx !== want.job_index) begin
                $error("job_index: expected %0d, got %0d", want.job_index, idx);
                errors++;
            end
            if (comp !== want.completion) begin
                $error("finish_time: expected %0d, got %0d", want.completion, comp);
                errors++;
            end
            if (tat !== want.turnaround) begin
                $error("turn_time: expected %0d, got %0d", want.turnaround, tat);
                errors++;
            end
            if (wt !== want.waiting) begin
                $error("wait_units: expected %0d, got %0d", want.waiting, wt);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_result: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return timings_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [ARR_W-1:0]     i_arrival_time;
    logic [BURST_W-1:0]   i_burst_time;
    logic [PRIO_W-1:0]    i_priority_req;
    logic                 i_last_job;
    logic                 o_valid;
    logic [JOB_IDX_W-1:0] o_job_index;
    logic [TOUT_W-1:0]    o_finish_time;
    logic [TOUT_W-1:0]    o_turn_time;
    logic [TOUT_W-1:0]    o_wait_units;
    logic                 o_last_result;

    t_timing_board board = new();
    int            burst_left;

    preemptive_priority_scheduler_core #(
        .NUM_SLOTS(DEF_NUM_SLOTS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_arrival_time   (i_arrival_time),
        .i_burst_time     (i_burst_time),
        .i_priority_req   (i_priority_req),
        .i_last_job       (i_last_job),
        .o_valid          (o_valid),
        .o_job_index      (o_job_index),
        .o_finish_time    (o_finish_time),
        .o_turn_time      (o_turn_time),
        .o_wait_units     (o_wait_units),
        .o_last_result    (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_job(i_arrival_time, i_burst_time, i_priority_req, i_last_job);
            end
            if (o_valid) begin
                board.check_result(o_job_index, o_finish_time, o_turn_time,
                                   o_wait_units, o_last_result);
            end
        end
    end

    task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bur,
                            input logic [PRIO_W-1:0] pr, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start          <= 1'b1;
        i_arrival_time <= arr;
        i_burst_time   <= bur;
        i_priority_req <= pr;
        i_last_job     <= last;
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every pending result is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    initial begin
        int               random_sent;
        int               set_size;
        bit               wide;
        logic [ARR_W-1:0] arr;
        logic [BURST_W-1:0] bur;
        logic [PRIO_W-1:0]  pr;
        logic             last;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_arrival_time = '0;
        i_burst_time   = '0;
        i_priority_req = '0;
        i_last_job     = 1'b0;
        burst_left     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_job(10'd0, 10'd0, 8'd0, 1'b1);
        send_job(10'd1023, 10'd1023, 8'd255, 1'b1);

        send_job(10'd0, 10'd5, 8'd10, 1'b0);
        send_job(10'd2, 10'd3, 8'd3, 1'b0);
        send_job(10'd2, 10'd2, 8'd3, 1'b0);
        send_job(10'd20, 10'd1, 8'd255, 1'b1);

        for (int i = 0; i < DEF_NUM_SLOTS; i++) begin
            send_job(ARR_W'(i * 2), BURST_W'(i % 5), PRIO_W'((15 - i) * 17), 1'b0);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        random_sent = 0;
        while (random_sent < RANDOM_JOBS) begin
            wide     = ($urandom_range(0, 5) == 0);
            set_size = wide ? $urandom_range(1, 3) : $urandom_range(1, DEF_NUM_SLOTS);
            for (int k = 0; k < set_size; k++) begin
                if (wide) begin
                    arr = ARR_W'($urandom_range(0, 1023));
                    bur = BURST_W'($urandom_range(0, 1023));
                end else begin
                    arr = ARR_W'($urandom_range(0, 63));
                    bur = BURST_W'($urandom_range(0, 20));
                end
                pr = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 3))
                                                 : PRIO_W'($urandom_range(0, 255));
                if (k != set_size - 1) begin
                    last = 1'b0;
                end else if (set_size == DEF_NUM_SLOTS) begin
                    last = 1'($urandom_range(0, 1));
                end else begin
                    last = 1'b1;
                end
                send_job(arr, bur, pr, last);
            end
            random_sent += set_size;
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
                repeat (4) @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("Ran %0d job requests through %0d schedules (%0d started by a full store).",
                 board.jobs_seen, board.schedules, board.full_starts);
        $display("Checked %0d job timings; longest schedule ran to time %0d.",
                 board.checked, board.latest_finish);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timed out with %0d job timings still pending.", board.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule
